>>> hdl/length_prefixed_deframer_macros.svh
// Assertion macros for the length-prefixed deframer.
// Included by the top level; expects clk and rst_n in scope.
`ifndef LENGTH_PREFIXED_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPD_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("deframer check failed");

// Next-cycle implication, checked outside reset.
`define LPD_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("deframer check failed");

`endif

>>> hdl/lpd_pkg.sv
// Package for the length-prefixed deframer: header constants and the
// per-byte result record. No dependencies.
`default_nettype none

package lpd_pkg;

    // Header is a 16-bit length field followed by a 16-bit message type.
    localparam int unsigned HDR_BYTES = 4;
    localparam logic [2:0] HDR_COUNT_DONE = 3'(HDR_BYTES);
    localparam logic [2:0] HDR_COUNT_LAST = 3'(HDR_BYTES - 1);
    // The length field counts the type field as well as the body.
    localparam logic [15:0] LEN_OVERHEAD = 16'd2;

    typedef struct packed {
        logic [7:0]  echo_byte;
        logic        in_header;
        logic [15:0] msg_type;
        logic [15:0] body_length;
        logic [15:0] byte_offset;
        logic        frame_end;
        logic        length_error;
    } lpd_result_t;

endpackage

`default_nettype wire

>>> hdl/lpd_parse.sv
// Frame state tracker of the deframer: header collection and body counting.
// Depends on lpd_pkg.
`default_nettype none

module lpd_parse
    import lpd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire logic [7:0]  cur_byte,
    output lpd_result_t      result
);

    logic [23:0] hdr_bytes_reg,  hdr_bytes_next;
    logic [2:0]  hdr_count_reg,  hdr_count_next;
    logic [15:0] frame_type_reg, frame_type_next;
    logic [15:0] body_len_reg,   body_len_next;
    logic [15:0] body_count_reg, body_count_next;

    always_comb
    begin
        logic [15:0] len_field;
        logic [15:0] typ;
        logic [15:0] blen;
        logic [15:0] count_inc;
        logic        done;

        hdr_bytes_next  = hdr_bytes_reg;
        hdr_count_next  = hdr_count_reg;
        frame_type_next = frame_type_reg;
        body_len_next   = body_len_reg;
        body_count_next = body_count_reg;

        len_field = hdr_bytes_reg[23:8];
        typ       = {hdr_bytes_reg[7:0], cur_byte};
        blen      = '0;
        count_inc = body_count_reg + 16'd1;
        done      = 1'b0;

        result              = '0;
        result.echo_byte    = cur_byte;

        if (hdr_count_reg < HDR_COUNT_DONE)
        begin
            result.in_header   = 1'b1;
            result.byte_offset = {13'd0, hdr_count_reg};
            if (hdr_count_reg < HDR_COUNT_LAST)
            begin
                hdr_bytes_next = {hdr_bytes_reg[15:0], cur_byte};
                hdr_count_next = hdr_count_reg + 3'd1;
            end
            else
            begin
                result.msg_type = typ;
                if (len_field < LEN_OVERHEAD)
                begin
                    // A short length field cannot hold the type; end the frame empty.
                    result.length_error = 1'b1;
                    done = 1'b1;
                end
                else
                begin
                    blen = len_field - LEN_OVERHEAD;
                    done = (blen == 16'd0);
                end
                result.body_length = blen;
                if (!done)
                begin
                    hdr_count_next  = HDR_COUNT_DONE;
                    frame_type_next = typ;
                    body_len_next   = blen;
                    body_count_next = '0;
                end
            end
        end
        else
        begin
            result.msg_type    = frame_type_reg;
            result.body_length = body_len_reg;
            result.byte_offset = body_count_reg;
            body_count_next    = count_inc;
            done = (count_inc >= body_len_reg);
        end

        result.frame_end = done;
        if (done)
        begin
            hdr_bytes_next  = '0;
            hdr_count_next  = '0;
            frame_type_next = '0;
            body_len_next   = '0;
            body_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_bytes_reg  <= '0;
            hdr_count_reg  <= '0;
            frame_type_reg <= '0;
            body_len_reg   <= '0;
            body_count_reg <= '0;
        end
        else if (advance)
        begin
            hdr_bytes_reg  <= hdr_bytes_next;
            hdr_count_reg  <= hdr_count_next;
            frame_type_reg <= frame_type_next;
            body_len_reg   <= body_len_next;
            body_count_reg <= body_count_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/length_prefixed_deframer.sv
// Top level of the length-prefixed deframer: input register, parser and result register.
// Depends on lpd_pkg, lpd_parse and length_prefixed_deframer_macros.svh.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------------------
//   in      | to block  | in_valid / in_ready    | rx_byte
//   out     | from block| out_valid / out_ready  | echo_byte, in_header, msg_type, body_length,
//           |           |                        | byte_offset, frame_end, length_error
//
// Every received byte yields exactly one result, through the input register and then the result register.
// One byte per clock is sustained while out_ready holds; the frame state update for a body byte
// is a single 16-bit increment and compare between the input register and the result register.
// Reset clears the frame state, so the first byte after reset starts a new header.
// A stall on the output holds the result register; the input register still takes
// one more byte, and in_ready then drops until the result is taken.
`default_nettype none

`include "length_prefixed_deframer_macros.svh"

module length_prefixed_deframer
    import lpd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       echo_byte,
    output logic             in_header,
    output logic [15:0]      msg_type,
    output logic [15:0]      body_length,
    output logic [15:0]      byte_offset,
    output logic             frame_end,
    output logic             length_error
);

    // Input register: holds the byte until the parser can move it on.
    logic        stage_valid_reg;
    logic [7:0]  stage_byte_reg;

    // Result register.
    logic        res_valid_reg;
    lpd_result_t res_reg;

    lpd_result_t parse_result;
    logic        advance;

    // A byte moves from the input register into the result register whenever the
    // result register is empty or its content is being taken in this cycle.
    assign advance  = stage_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stage_byte_reg <= rx_byte;
        end
    end

    // The parser computes the result of the byte in the input register from the
    // current frame state, and commits its state update only on an advance.
    lpd_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .cur_byte (stage_byte_reg),
        .result   (parse_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (!res_valid_reg || out_ready)
        begin
            res_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= parse_result;
        end
    end

    assign out_valid    = res_valid_reg;
    assign echo_byte    = res_reg.echo_byte;
    assign in_header    = res_reg.in_header;
    assign msg_type     = res_reg.msg_type;
    assign body_length  = res_reg.body_length;
    assign byte_offset  = res_reg.byte_offset;
    assign frame_end    = res_reg.frame_end;
    assign length_error = res_reg.length_error;

    // A short length field is only reported on the last header byte, which ends the frame.
    `LPD_ASSERT_NOW(a_err_ends_frame, out_valid && length_error, frame_end && in_header && (byte_offset == 16'd3))

    // Early header bytes carry no type or length and never end a frame.
    `LPD_ASSERT_NOW(a_early_header, out_valid && in_header && (byte_offset != 16'd3), (msg_type == 16'd0) && (body_length == 16'd0) && !frame_end)

    // A body byte ends the frame exactly when it is the last byte of the body.
    `LPD_ASSERT_NOW(a_body_end, out_valid && !in_header, frame_end == (({1'b0, byte_offset} + 17'd1) == {1'b0, body_length}))

    // A byte held in the input register during a stall is kept for the parser.
    `LPD_ASSERT_NEXT(a_stage_hold, stage_valid_reg && !advance, stage_valid_reg && $stable(stage_byte_reg))

endmodule

`default_nettype wire

>>> dv/length_prefixed_deframer_tb.sv
// Self-checking testbench for length_prefixed_deframer: directed frames, then random
// frame traffic with truncated headers.
// Depends on lpd_pkg and the length_prefixed_deframer RTL.
`timescale 1ns / 1ps

module length_prefixed_deframer_tb;
    import lpd_pkg::*;

    // The timeout covers a few thousand bytes, each one facing the longest sender
    // gap and the longest receiver stall, many times over.
    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned RANDOM_BYTES = 900;
    // The block answers through its input and result registers; this is a comfortable margin
    // in which no further transfer may appear.
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned MAX_REPORTS = 200;

    // Frame predictor and the queue of results it has worked out. Each byte accepted
    // by the block is fed to the predictor; each result transfer is checked
    // against the oldest entry of the queue.
    class frame_scoreboard;
        lpd_result_t expected_q[$];
        int unsigned error_count = 0;
        logic [23:0] hdr_shift = '0;
        logic [2:0]  hdr_taken = '0;
        logic [15:0] cur_type = '0;
        logic [15:0] cur_body_len = '0;
        logic [15:0] body_taken = '0;

        function void clear_frame();
            hdr_shift = '0;
            hdr_taken = '0;
            cur_type = '0;
            cur_body_len = '0;
            body_taken = '0;
        endfunction

        function void note_byte(logic [7:0] b);
            lpd_result_t want;
            logic [15:0] len_field;
            want = '0;
            want.echo_byte = b;
            if (hdr_taken < HDR_COUNT_DONE)
            begin
                want.in_header = 1'b1;
                want.byte_offset = 16'(hdr_taken);
                if (hdr_taken < HDR_COUNT_LAST)
                begin
                    hdr_shift = {hdr_shift[15:0], b};
                    hdr_taken = hdr_taken + 3'd1;
                end
                else
                begin
                    len_field = hdr_shift[23:8];
                    want.msg_type = {hdr_shift[7:0], b};
                    if (len_field < LEN_OVERHEAD)
                    begin
                        want.length_error = 1'b1;
                        want.frame_end = 1'b1;
                    end
                    else
                    begin
                        want.body_length = len_field - LEN_OVERHEAD;
                        want.frame_end = (want.body_length == 16'd0);
                    end
                    if (want.frame_end)
                    begin
                        clear_frame();
                    end
                    else
                    begin
                        hdr_taken = HDR_COUNT_DONE;
                        cur_type = want.msg_type;
                        cur_body_len = want.body_length;
                        body_taken = '0;
                    end
                end
            end
            else
            begin
                want.msg_type = cur_type;
                want.body_length = cur_body_len;
                want.byte_offset = body_taken;
                body_taken = body_taken + 16'd1;
                if (body_taken >= cur_body_len)
                begin
                    want.frame_end = 1'b1;
                    clear_frame();
                end
            end
            expected_q.push_back(want);
        endfunction

        function void report(string field, logic [15:0] want, logic [15:0] got);
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s expected %h, got %h", $time, field, want, got);
        endfunction

        function void check_result(lpd_result_t got);
            lpd_result_t want;
            if (expected_q.size() == 0)
            begin
                report("unexpected result, echo_byte", 16'hxxxx, 16'(got.echo_byte));
                return;
            end
            want = expected_q.pop_front();
            if (got.echo_byte !== want.echo_byte)
                report("echo_byte", 16'(want.echo_byte), 16'(got.echo_byte));
            if (got.in_header !== want.in_header)
                report("in_header", 16'(want.in_header), 16'(got.in_header));
            if (got.msg_type !== want.msg_type)
                report("msg_type", want.msg_type, got.msg_type);
            if (got.body_length !== want.body_length)
                report("body_length", want.body_length, got.body_length);
            if (got.byte_offset !== want.byte_offset)
                report("byte_offset", want.byte_offset, got.byte_offset);
            if (got.frame_end !== want.frame_end)
                report("frame_end", 16'(want.frame_end), 16'(got.frame_end));
            if (got.length_error !== want.length_error)
                report("length_error", 16'(want.length_error), 16'(got.length_error));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // All inputs start at known values; reset is held low from time zero.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  echo_byte;
    logic        in_header;
    logic [15:0] msg_type;
    logic [15:0] body_length;
    logic [15:0] byte_offset;
    logic        frame_end;
    logic        length_error;

    frame_scoreboard sb;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent = 0;

    // Stream alignment as the block will see it, kept by the stimulus side only.
    // It lets the random part resynchronize after a truncated header and keeps
    // stray bytes from landing on the high byte of a length field.
    int unsigned align_hdr = 0;
    logic [15:0] align_len = '0;
    int unsigned align_body_left = 0;

    // When set, the matching side runs back to back with no idle cycles.
    bit in_no_idle = 1'b0;
    bit out_no_idle = 1'b0;

    length_prefixed_deframer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .echo_byte    (echo_byte),
        .in_header    (in_header),
        .msg_type     (msg_type),
        .body_length  (body_length),
        .byte_offset  (byte_offset),
        .frame_end    (frame_end),
        .length_error (length_error)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function bit stream_aligned();
        return (align_hdr == 0) && (align_body_left == 0);
    endfunction

    // Follows the byte through the framing so the stimulus knows where the
    // next byte will land.
    function void track_alignment(logic [7:0] b);
        if (align_body_left > 0)
        begin
            align_body_left--;
        end
        else
        begin
            if (align_hdr == 0)
                align_len[15:8] = b;
            else if (align_hdr == 1)
                align_len[7:0] = b;
            if (align_hdr == 3)
            begin
                align_hdr = 0;
                align_body_left = (align_len > LEN_OVERHEAD) ? int'(align_len - LEN_OVERHEAD) : 0;
            end
            else
            begin
                align_hdr++;
            end
        end
    endfunction

    // Offers one byte after a random gap and holds it until the transfer. A
    // back-to-back byte keeps in_valid high, so the valid line gets a single
    // assignment per edge.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if ($urandom_range(0, 31) == 0)
            in_no_idle = !in_no_idle;
        gap = in_no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(b);
        track_alignment(b);
        bytes_sent++;
    endtask

    // A complete frame: big-endian length field and type, then a random body as long as
    // the field announces, less the type field.
    task automatic send_frame(input logic [15:0] len_field, input logic [15:0] mtype);
        int unsigned body_bytes;
        body_bytes = (len_field > LEN_OVERHEAD) ? int'(len_field - LEN_OVERHEAD) : 0;
        send_byte(len_field[15:8]);
        send_byte(len_field[7:0]);
        send_byte(mtype[15:8]);
        send_byte(mtype[7:0]);
        for (int unsigned i = 0; i < body_bytes; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // Drops in_valid and holds off until every outstanding result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Mostly small bodies, with some short-length errors, empty bodies and
    // a few bodies of 65 to 300 bytes.
    function automatic logic [15:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 16'($urandom_range(0, 1));
        else if (r < 12)
            return LEN_OVERHEAD;
        else if (r < 75)
            return LEN_OVERHEAD + 16'($urandom_range(1, 12));
        else if (r < 95)
            return LEN_OVERHEAD + 16'($urandom_range(13, 64));
        else
            return LEN_OVERHEAD + 16'($urandom_range(65, 300));
    endfunction

    // Result side: draws a stall for every result, then takes the next transfer and
    // checks it. Values are sampled at the edge, before any update of this step.
    initial
    begin
        int unsigned stall;
        lpd_result_t got;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                out_no_idle = !out_no_idle;
            stall = out_no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
            got.echo_byte = echo_byte;
            got.in_header = in_header;
            got.msg_type = msg_type;
            got.body_length = body_length;
            got.byte_offset = byte_offset;
            got.frame_end = frame_end;
            got.length_error = length_error;
            sb.check_result(got);
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int unsigned random_end;
        int unsigned noise_bytes;
        logic [7:0] b;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames: both short lengths that raise the error, with the
        // type still parsed (all ones, then all zeros), an empty body that ends on
        // the last header byte, and one- and two-byte bodies of random bytes.
        send_frame(16'h0000, 16'hFFFF);
        send_frame(16'h0001, 16'h0000);
        send_frame(16'h0002, 16'h8001);
        send_frame(16'h0003, 16'h1234);
        send_frame(16'h0004, 16'hA55A);

        // Let the block run completely dry once before the random traffic.
        wait_drained();

        // Random traffic: mostly well-formed frames, and now and then a header
        // cut short by random bytes. A cut-short header is completed with random
        // bytes before the next frame starts, so framing is regained each time.
        random_end = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < random_end)
        begin
            while (!stream_aligned())
                send_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 99) < 85)
            begin
                send_frame(pick_length(), 16'($urandom_range(0, 16'hFFFF)));
            end
            else
            begin
                noise_bytes = $urandom_range(1, 3);
                for (int unsigned i = 0; i < noise_bytes; i++)
                begin
                    // The high byte of a length field stays small so that a stray
                    // header cannot announce a huge body.
                    if (stream_aligned())
                        b = 8'($urandom_range(0, 1));
                    else
                        b = 8'($urandom_range(0, 255));
                    send_byte(b);
                end
            end
        end
        while (!stream_aligned())
            send_byte(8'($urandom_range(0, 255)));

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
